// ===== rtl/core/amac_pkg.sv =====
// Package for the asymmetric moving average core: sizes, register codes and
// the structs passed between the front end, the job queue and the back end.
// No dependencies.
`default_nettype none
package amac_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int AVG_W       = 24;
  localparam int FRAC_BITS   = 8;
  localparam int CFG_W       = 6;
  localparam int CFG_ADDR_W  = 1;
  localparam int MAX_HISTORY = 32;
  localparam int MAX_FUTURE  = 32;
  localparam int WIN_DEPTH   = MAX_HISTORY + MAX_FUTURE;
  // ring is twice the window so the front end may run a few words ahead
  localparam int RING_DEPTH  = 2 * WIN_DEPTH;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int CNT_W       = $clog2(WIN_DEPTH) + 1;
  localparam int SUM_W       = SAMPLE_W + $clog2(WIN_DEPTH);
  localparam int DVD_W       = SUM_W + FRAC_BITS;
  localparam int STEP_W      = $clog2(DVD_W);
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_ADDR_W-1:0] CFG_HISTORY = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FUTURE  = 1'd1;

  typedef struct packed {
    logic [PTR_W-1:0] wp;   // ring slot after this sample
    logic [CNT_W-1:0] n;    // samples held in the curve, saturated
    logic [CFG_W-1:0] h;    // effective history
    logic [CFG_W-1:0] f;    // effective future
    logic             last;
  } job_t;

  typedef struct packed {
    logic                       en;
    logic [PTR_W-1:0]           addr;
    logic signed [SAMPLE_W-1:0] data;
  } ring_wr_t;

endpackage
`default_nettype wire

// ===== rtl/core/amac_front.sv =====
// Front end: configuration registers, input handshake, ring write and job
// classification. Depends on amac_pkg.
`default_nettype none
module amac_front (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_valid,
  input  wire  [amac_pkg::CFG_ADDR_W-1:0]  cfg_index,
  input  wire  [amac_pkg::CFG_W-1:0]       cfg_data,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire  [amac_pkg::SAMPLE_W-1:0]    s_tdata,
  input  wire                              s_tlast,
  input  wire                              fifo_full,
  output logic                             push,
  output amac_pkg::job_t                   job,
  output amac_pkg::ring_wr_t               ring_wr
);

  logic [amac_pkg::CFG_W-1:0] history;
  logic [amac_pkg::CFG_W-1:0] future;
  logic [amac_pkg::PTR_W-1:0] wp;
  logic [amac_pkg::CNT_W-1:0] seen;
  logic [amac_pkg::CNT_W-1:0] seen_inc;
  logic [amac_pkg::CFG_W-1:0] eff_h;
  logic [amac_pkg::CFG_W-1:0] eff_f;

  always_comb begin
    eff_h = (history > amac_pkg::CFG_W'(amac_pkg::MAX_HISTORY)) ?
            amac_pkg::CFG_W'(amac_pkg::MAX_HISTORY) : history;
    if (future == '0) begin
      eff_f = amac_pkg::CFG_W'(1);
    end else if (future > amac_pkg::CFG_W'(amac_pkg::MAX_FUTURE)) begin
      eff_f = amac_pkg::CFG_W'(amac_pkg::MAX_FUTURE);
    end else begin
      eff_f = future;
    end
    seen_inc = (seen < amac_pkg::CNT_W'(amac_pkg::WIN_DEPTH)) ?
               seen + amac_pkg::CNT_W'(1) : seen;
  end

  assign s_tready     = ~fifo_full;
  assign push         = s_tvalid & ~fifo_full;
  assign job.wp       = wp + amac_pkg::PTR_W'(1);
  assign job.n        = seen_inc;
  assign job.h        = eff_h;
  assign job.f        = eff_f;
  assign job.last     = s_tlast;
  assign ring_wr.en   = push;
  assign ring_wr.addr = wp;
  assign ring_wr.data = s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= amac_pkg::CFG_W'(4);
      future  <= amac_pkg::CFG_W'(4);
      wp      <= '0;
      seen    <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          amac_pkg::CFG_HISTORY: history <= cfg_data;
          amac_pkg::CFG_FUTURE:  future  <= cfg_data;
          default: ;
        endcase
      end
      if (push) begin
        wp   <= wp + amac_pkg::PTR_W'(1);
        seen <= s_tlast ? '0 : seen_inc;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/amac_fifo.sv =====
// Short job queue between front and back end.
// Depends on amac_pkg.
`default_nettype none
module amac_fifo (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  amac_pkg::job_t  din,
  output logic            full,
  input  wire             pop,
  output amac_pkg::job_t  dout,
  output logic            empty
);

  amac_pkg::job_t                  mem [amac_pkg::FIFO_DEPTH];
  logic [amac_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [amac_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [amac_pkg::FIFO_CNT_W-1:0] count;

  assign full  = (count == amac_pkg::FIFO_CNT_W'(amac_pkg::FIFO_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + amac_pkg::FIFO_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + amac_pkg::FIFO_PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + amac_pkg::FIFO_CNT_W'(1);
        2'b01:   count <= count - amac_pkg::FIFO_CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/amac_div.sv =====
// Restoring divider, one quotient bit per cycle, for the scaled window mean.
// Depends on amac_pkg.
`default_nettype none
module amac_div (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  input  wire  [amac_pkg::DVD_W-1:0]    dividend,
  input  wire  [amac_pkg::CNT_W-1:0]    divisor,
  output logic                          done,
  output logic [amac_pkg::DVD_W-1:0]    quotient
);

  logic                          busy;
  logic [amac_pkg::STEP_W-1:0]   cnt;
  logic [amac_pkg::DVD_W-1:0]    work;
  logic [amac_pkg::CNT_W-1:0]    rem;
  logic [amac_pkg::CNT_W-1:0]    dvs;
  logic [amac_pkg::CNT_W:0]      shifted;
  logic [amac_pkg::CNT_W:0]      diff;
  logic                          ge;

  always_comb begin
    shifted = {rem, work[amac_pkg::DVD_W-1]};
    diff    = shifted - {1'b0, dvs};
    ge      = (shifted >= {1'b0, dvs});
  end

  assign quotient = work;

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      work <= {work[amac_pkg::DVD_W-2:0], ge};
      rem  <= ge ? diff[amac_pkg::CNT_W-1:0] : shifted[amac_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + amac_pkg::STEP_W'(1);
        if (cnt == amac_pkg::STEP_W'(amac_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/amac_back.sv =====
// Back end: sample ring, window sum sequencer, divider and output register.
// Depends on amac_pkg and amac_div.
`default_nettype none
module amac_back (
  input  wire                             clk,
  input  wire                             rst,
  input  amac_pkg::ring_wr_t              ring_wr,
  input  wire                             job_valid,
  input  amac_pkg::job_t                  job,
  output logic                            pop,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  output logic [amac_pkg::AVG_W-1:0]      m_tdata,
  output logic                            m_tlast
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SUM    = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DWAIT  = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;
  localparam logic [2:0] S_TRIM   = 3'd6;
  localparam logic [2:0] S_SUB    = 3'd7;

  logic signed [amac_pkg::SAMPLE_W-1:0] ring [amac_pkg::RING_DEPTH];
  logic signed [amac_pkg::SAMPLE_W-1:0] rd_data;
  logic [amac_pkg::PTR_W-1:0]           rd_addr;
  logic                                 rdv;

  logic [2:0]                           state;
  amac_pkg::job_t                       jb;
  logic [amac_pkg::CNT_W-1:0]           j;
  logic [amac_pkg::CNT_W-1:0]           len;
  logic [amac_pkg::CNT_W-1:0]           t;
  logic signed [amac_pkg::SUM_W-1:0]    acc;

  logic [amac_pkg::CNT_W-1:0]           nf;
  logic [amac_pkg::CNT_W-1:0]           j0;
  logic [amac_pkg::CNT_W-1:0]           span0;
  logic [amac_pkg::CNT_W-1:0]           len0;
  logic [amac_pkg::CNT_W-1:0]           span1;
  logic [amac_pkg::CNT_W-1:0]           len1;
  logic                                 skip;
  logic                                 out_free;
  logic                                 out_load;

  logic                                 neg;
  logic [amac_pkg::SUM_W-1:0]           mag;
  logic [amac_pkg::DVD_W-1:0]           quotient;
  logic [amac_pkg::DVD_W-1:0]           q_signed;
  logic                                 div_start;
  logic                                 div_done;

  // ring store: one write port from the front end, one registered read
  always_ff @(posedge clk) begin
    if (ring_wr.en) begin
      ring[ring_wr.addr] <= ring_wr.data;
    end
    rd_data <= ring[rd_addr];
  end

  always_comb begin
    nf    = (job.n < amac_pkg::CNT_W'(job.f)) ? job.n : amac_pkg::CNT_W'(job.f);
    j0    = job.last ? nf - amac_pkg::CNT_W'(1)
                     : amac_pkg::CNT_W'(job.f) - amac_pkg::CNT_W'(1);
    span0 = j0 + amac_pkg::CNT_W'(1) + amac_pkg::CNT_W'(job.h);
    len0  = (span0 < job.n) ? span0 : job.n;
    skip  = ~job.last & (job.n < amac_pkg::CNT_W'(job.f));
    span1 = j + amac_pkg::CNT_W'(jb.h);
    len1  = (span1 < jb.n) ? span1 : jb.n;
    pop   = (state == S_IDLE) & job_valid;
    out_free = ~m_tvalid | m_tready;
    out_load = (state == S_OUT) & out_free;
    if (state == S_TRIM) begin
      rd_addr = jb.wp - amac_pkg::PTR_W'(1) - amac_pkg::PTR_W'(len);
    end else begin
      rd_addr = jb.wp - amac_pkg::PTR_W'(1) - amac_pkg::PTR_W'(t);
    end
    neg       = acc[amac_pkg::SUM_W-1];
    mag       = neg ? amac_pkg::SUM_W'(-acc) : amac_pkg::SUM_W'(acc);
    q_signed  = neg ? (~quotient + amac_pkg::DVD_W'(1)) : quotient;
    div_start = (state == S_DSTART);
  end

  amac_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({mag, {amac_pkg::FRAC_BITS{1'b0}}}),
    .divisor  (len),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rdv      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rdv <= (state == S_SUM);
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid & m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            jb  <= job;
            j   <= j0;
            len <= len0;
            t   <= '0;
            acc <= '0;
            if (!skip) state <= S_SUM;
          end
        end
        S_SUM: begin
          if (rdv) acc <= acc + amac_pkg::SUM_W'(rd_data);
          t <= t + amac_pkg::CNT_W'(1);
          if (t == len - amac_pkg::CNT_W'(1)) state <= S_DRAIN;
        end
        S_DRAIN: begin
          acc   <= acc + amac_pkg::SUM_W'(rd_data);
          state <= S_DSTART;
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_tdata  <= q_signed[amac_pkg::AVG_W-1:0];
            m_tlast  <= jb.last & (j == '0);
            if (jb.last && (j != '0)) begin
              j <= j - amac_pkg::CNT_W'(1);
              if (len1 < len) begin
                len   <= len1;
                state <= S_TRIM;
              end else begin
                state <= S_DSTART;
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_TRIM: state <= S_SUB;
        S_SUB: begin
          // drop the oldest sample that left the shrinking window
          acc   <= acc - amac_pkg::SUM_W'(rd_data);
          state <= S_DSTART;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/asymmetric_moving_average_core.sv =====
// Top level of the asymmetric moving average core.
// Depends on amac_pkg, amac_front, amac_fifo, amac_back (and amac_div).
//
// Use:
//   s_* carries one sample word per handshake: s_tdata is the signed sample,
//   s_tlast marks the last sample of a curve. m_* carries averages: m_tdata
//   is the window mean times 256 (signed, truncated toward zero), m_tlast
//   marks the last average of a curve. The cfg channel writes history
//   (index 0) and future (index 1); it is always ready and is meant to be
//   written only while the core is idle.
// Sequence:
//   for an average (back end idle) the back end pops the sample's job, reads
//   len ring words (len is the clipped window, up to 64), adds the last
//   read in a drain step, starts the bit-serial divider, waits until it is
//   done and loads the output register. It pops no new job before that;
//   a sample that only fills the window is popped without an average.
//   Flushed averages at curve end reuse the sum: an optional trim and
//   subtract step drops the oldest sample, then start, divide and output.
// Reset:
//   synchronous, clears pointers, counters, queue and output valid;
//   registers return to history 4, future 4.
// Stalls:
//   when m_tready is low the output word holds and the back end waits; the
//   front end keeps taking samples until the two-entry job queue fills.
`default_nettype none
module asymmetric_moving_average_core (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [amac_pkg::CFG_ADDR_W-1:0]  cfg_index,
  input  wire  [amac_pkg::CFG_W-1:0]       cfg_data,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire  [amac_pkg::SAMPLE_W-1:0]    s_tdata,   // [15:0] sample
  input  wire                              s_tlast,   // end_of_curve
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [amac_pkg::AVG_W-1:0]       m_tdata,   // [23:0] average
  output logic                             m_tlast    // final_output
);

  logic                fifo_full;
  logic                fifo_empty;
  logic                push;
  logic                pop;
  amac_pkg::job_t      job_in;
  amac_pkg::job_t      job_out;
  amac_pkg::ring_wr_t  ring_wr;

  assign cfg_ready = 1'b1;

  amac_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .fifo_full (fifo_full),
    .push      (push),
    .job       (job_in),
    .ring_wr   (ring_wr)
  );

  amac_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (job_in),
    .full  (fifo_full),
    .pop   (pop),
    .dout  (job_out),
    .empty (fifo_empty)
  );

  amac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ring_wr   (ring_wr),
    .job_valid (~fifo_empty),
    .job       (job_out),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire

// ===== rtl/core/amac_checker.sv =====
// Port-level checks for the asymmetric moving average core, with bind.
// Depends on amac_pkg.
`default_nettype none
module amac_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          s_tready,
  input wire                          m_tvalid,
  input wire                          m_tready,
  input wire [amac_pkg::AVG_W-1:0]    m_tdata,
  input wire                          m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_rst_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

endmodule

bind asymmetric_moving_average_core amac_checker u_amac_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for asymmetric_moving_average_core: random curves with
// idling and a long receiver hold-off, averages checked by an in-bench predictor.
// Depends on amac_pkg and the core RTL.
`timescale 1ns / 1ps

class avg_scoreboard;
  logic signed [15:0] ring[64];
  int unsigned wp, seen;
  int unsigned hist = 4, fut = 4;
  logic [23:0] avg_q[$];
  bit          fin_q[$];
  int unsigned errors, checked;

  function logic [23:0] mean_of(int unsigned len);
    longint s, a;
    s = 0;
    for (int unsigned t = 0; t < len; t++) s += ring[(wp + 63 - t) % 64];
    a = (s * 256) / longint'(len);
    if (a > 8388607) a = 8388607;
    if (a < -8388608) a = -8388608;
    return a[23:0];
  endfunction

  function void set_reg(bit idx, logic [5:0] v);
    if (idx == amac_pkg::CFG_HISTORY) hist = v;
    else fut = v;
  endfunction

  function void queue_expected(logic [23:0] avg, bit last);
    avg_q.insert(avg_q.size(), avg);
    fin_q.insert(fin_q.size(), last);
  endfunction

  // note an accepted sample and queue the averages it produces
  function void note_sample(logic [15:0] smp, bit last);
    int unsigned h, f, n, len, jmax;
    h = (hist > 32) ? 32 : hist;
    f = (fut < 1) ? 1 : ((fut > 32) ? 32 : fut);
    ring[wp] = smp;
    wp = (wp + 1) % 64;
    if (seen < 64) seen++;
    n = seen;
    if (!last) begin
      if (n >= f) begin
        len = (h + f > n) ? n : h + f;
        queue_expected(mean_of(len), 0);
      end
      return;
    end
    jmax = ((n < f) ? n : f) - 1;
    for (int j = jmax; j >= 0; j--) begin
      len = j + 1 + h;
      if (len > n) len = n;
      queue_expected(mean_of(len), j == 0);
    end
    seen = 0;
  endfunction

  function void check_word(logic [23:0] avg, bit last);
    logic [23:0] ea;
    bit ef;
    checked++;
    if (avg_q.size() == 0) begin
      $error("average word with nothing expected: average=%0d", $signed(avg));
      errors++;
      return;
    end
    ea = avg_q.pop_front();
    ef = fin_q.pop_front();
    if (ea !== avg) begin
      $error("average: expected %0d, got %0d", $signed(ea), $signed(avg));
      errors++;
    end
    if (ef !== last) begin
      $error("final_output: expected %0d, got %0d", ef, last);
      errors++;
    end
  endfunction
endclass

module tb_top;

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [amac_pkg::CFG_ADDR_W-1:0] cfg_index = amac_pkg::CFG_HISTORY;
  logic [amac_pkg::CFG_W-1:0] cfg_data = '0;
  logic s_tvalid = 0, s_tready, s_tlast = 0;
  logic [amac_pkg::SAMPLE_W-1:0] s_tdata = '0;
  logic m_tvalid, m_tlast;
  logic m_tready = 0;
  logic [amac_pkg::AVG_W-1:0] m_tdata;

  asymmetric_moving_average_core dut (.*);

  avg_scoreboard sb = new();
  int unsigned send_idle = 0, recv_stall = 0;   // percent
  bit hold_off = 0;
  longint unsigned cycles = 0;
  int unsigned sent = 0, curves = 0;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
    m_tready <= !rst && !hold_off && ($urandom_range(99) >= recv_stall);
  end

  // tvalid stays up after a handshake; it drops on an idle cycle or in drain
  task automatic send_word(logic [15:0] smp, bit last);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_tvalid <= 1; s_tdata <= smp; s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(smp, last);
    sent++;
    if (last) curves++;
  endtask

  task automatic send_curve(int unsigned len, int unsigned kind);
    logic [15:0] v;
    for (int unsigned i = 0; i < len; i++) begin
      case (kind)
        0: v = 16'($urandom);
        1: v = 16'h7fff;
        2: v = 16'h8000;
        default: v = $urandom_range(1) ? 16'h7fff : 16'h8000;
      endcase
      send_word(v, i == len - 1);
    end
  endtask

  // wait until every average is in, then let the back end settle
  task automatic drain();
    s_tvalid <= 0;
    while (sb.avg_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [amac_pkg::CFG_ADDR_W-1:0] idx,
                           logic [amac_pkg::CFG_W-1:0] v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
  endtask

  initial begin
    int unsigned hs[6] = '{0, 32, 63, 4, 1, 7};
    int unsigned fs[6] = '{1, 32, 0, 63, 4, 2};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes of samples, short curves, single-sample curve
    send_curve(6, 1);
    send_curve(6, 2);
    send_curve(1, 0);
    send_curve(3, 0);
    send_curve(9, 3);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(amac_pkg::CFG_HISTORY, amac_pkg::CFG_W'(hs[p]));
      write_reg(amac_pkg::CFG_FUTURE, amac_pkg::CFG_W'(fs[p]));
      cfg_valid <= 0;
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 56; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 56; end
        default: begin send_idle = 19; recv_stall = 19; end
      endcase
      if (p == 1) begin
        // output held off while further curves queue up behind the flush
        fork
          begin hold_off <= 1; repeat (3000) @(posedge clk); hold_off <= 0; end
          begin repeat (3) send_curve(8, 0); s_tvalid <= 0; end
        join
        @(posedge clk);
      end
      for (int c = 0; c < 4; c++)
        send_curve(($urandom_range(9) == 0) ? $urandom_range(70, 100)
                                            : $urandom_range(1, 12),
                   ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0);
      drain();
    end

    $display("Sent %0d samples in %0d curves; checked %0d averages.",
             sent, curves, sb.checked);
    $display("Covered history/future extremes, stalls and a long hold-off.");
    if (sb.errors == 0 && sb.avg_q.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/amac_pkg.sv
rtl/core/amac_front.sv
rtl/core/amac_fifo.sv
rtl/core/amac_div.sv
rtl/core/amac_back.sv
rtl/core/asymmetric_moving_average_core.sv
rtl/core/amac_checker.sv
tb/sv/tb_top.sv
